// ----- hdl/crf_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crf_pkg : shared types and constants of the comet ring frame renderer
// Sequencer states, effect phases, register indexes and fixed sizes.
// ============================================================================
package crf_pkg;

    // Largest ring the frame buffer holds, and the smallest ring used
    localparam int MAX_PIXELS = 64;
    localparam int MIN_PIXELS = 2;

    // Degrees in a full hue turn, and the width of one color sector
    localparam int HUE_TURN   = 360;
    localparam int HUE_SECTOR = 60;

    // Saturation point of the frame counter
    localparam logic [5:0] FRAMES_MAX = 6'd63;

    // Full channel intensity
    localparam logic [7:0] CH_FULL = 8'd255;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_COUNT  = 2'd0;
    localparam logic [1:0] CFG_TRAIL_LENGTH = 2'd1;
    localparam logic [1:0] CFG_START_HUE    = 2'd2;
    localparam logic [1:0] CFG_HUE_ADVANCE  = 2'd3;

    typedef enum logic [1:0] {
        PH_RUN,
        PH_FINISH,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MOD,
        S_SETUP,
        S_PAINT,
        S_DIV_C,
        S_DIV_X,
        S_WRITE,
        S_UPDATE
    } t_state_core;

    typedef enum logic [1:0] {
        R_NONE,
        R_READ,
        R_SHOW
    } t_state_read;

endpackage

// ----- hdl/crf_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crf_ram : generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ============================================================================
module crf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/comet_ring_frame_renderer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// comet_ring_frame_renderer_core : comet chase renderer for an LED ring
// Renders one frame per tick beat into a frame buffer and streams it out
// one pixel per result beat.
// ============================================================================
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  tick     | in        | i_valid / o_stall  | i_active
//  pixel    | out       | o_valid / i_stall  | o_pixel_index, o_red, o_green,
//           |           |                    | o_blue, o_frame_last, o_finished
//  config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  Each tick runs one shared restoring divider that resolves one quotient bit
//  per cycle: two quotients per trail pixel, plus a ring-position modulo up
//  front. Readout issues each pixel's registered frame buffer read, then
//  shows the pixel until it is taken.
//  Reset is synchronous; no clearing pass is needed, a per-frame written mask
//  makes unwritten pixels read black. o_stall is high from the tick beat until
//  the last pixel beat of the frame; a stalled pixel beat holds.
//
module comet_ring_frame_renderer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_active,

    output logic       o_valid,
    input  logic       i_stall,
    output logic [5:0] o_pixel_index,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_frame_last,
    output logic       o_finished,

    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    import crf_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0] r_pixel_count;
    logic [5:0] r_trail_len;
    logic [8:0] r_hue_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= 7'd24;
            r_trail_len   <= 6'd12;
            r_hue_adv     <= 9'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_COUNT:  r_pixel_count <= i_cfg_data[6:0];
                CFG_TRAIL_LENGTH: r_trail_len   <= i_cfg_data[5:0];
                CFG_HUE_ADVANCE:  r_hue_adv     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state_core r_state, n_state;
    t_state_read r_rstate, n_rstate;
    t_phase      r_phase, n_phase;

    logic [5:0]  r_ring_pos, n_ring_pos;
    logic [5:0]  r_frames, n_frames;
    logic [8:0]  r_cur_hue, n_cur_hue;
    logic [6:0]  r_off, n_off;

    logic        r_active, n_active;
    logic [5:0]  r_pos, n_pos;
    logic        r_fin, n_fin;

    // shared divider
    logic [19:0] r_rem, n_rem;
    logic [7:0]  r_quo, n_quo;
    logic [11:0] r_den, n_den;
    logic [2:0]  r_step, n_step;

    // painting
    logic [7:0]  r_c, n_c;
    logic [5:0]  r_i, n_i;
    logic [5:0]  r_idx, n_idx;
    logic [5:0]  r_drawn, n_drawn;
    logic [MAX_PIXELS-1:0] r_mask, n_mask;

    // readout
    logic [5:0]  r_k, n_k;

    // ------------------------------------------------------------------
    // Frame buffer
    // ------------------------------------------------------------------
    logic        w_ram_we;
    logic [23:0] w_ram_wdata;
    logic [23:0] w_ram_q;

    crf_ram #(
        .WIDTH (24),
        .DEPTH (MAX_PIXELS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_k),
        .o_rdata (w_ram_q)
    );

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [6:0]  w_p;
    logic [5:0]  w_idx_dec;
    logic [5:0]  w_next_pos;
    logic        w_finishing;

    // clamp the ring size
    always_comb begin
        if (r_pixel_count < 7'(MIN_PIXELS)) begin
            w_p = 7'(MIN_PIXELS);
        end else if (r_pixel_count > 7'(MAX_PIXELS)) begin
            w_p = 7'(MAX_PIXELS);
        end else begin
            w_p = r_pixel_count;
        end
    end

    // trail walks backward around the ring
    assign w_idx_dec   = (r_idx == 6'd0) ? 6'(w_p - 7'd1) : r_idx - 6'd1;
    assign w_next_pos  = ((7'(r_pos) + 7'd1) == w_p) ? 6'd0 : r_pos + 6'd1;
    assign w_finishing = (r_phase == PH_FINISH);

    // hue factor: distance of hue mod 120 from the nearest multiple of 120
    logic [8:0]  w_hq;
    logic [5:0]  w_f;

    always_comb begin
        if (r_cur_hue >= 9'd240) begin
            w_hq = r_cur_hue - 9'd240;
        end else if (r_cur_hue >= 9'd120) begin
            w_hq = r_cur_hue - 9'd120;
        end else begin
            w_hq = r_cur_hue;
        end
        if (w_hq <= 9'(HUE_SECTOR)) begin
            w_f = w_hq[5:0];
        end else begin
            w_f = 6'(9'd120 - w_hq);
        end
    end

    // dividends and divisors of the two color quotients
    logic [5:0]  w_lmj;
    logic [13:0] w_c_num;
    logic [19:0] w_x_num;
    logic [11:0] w_x_den;

    assign w_lmj   = r_trail_len - r_drawn;
    assign w_c_num = {w_lmj, 8'd0} - 14'(w_lmj);
    assign w_x_num = 20'(w_c_num) * 20'(w_f);
    assign w_x_den = {r_trail_len, 6'd0} - {4'd0, r_trail_len, 2'd0};

    // hue after one sweep, modulo a full turn
    logic [9:0]  w_hue_sum;
    logic [9:0]  w_hue_s1;
    logic [9:0]  w_hue_s2;
    logic [8:0]  w_start_hue;

    assign w_hue_sum   = 10'(r_cur_hue) + 10'(r_hue_adv);
    assign w_hue_s1    = (w_hue_sum >= 10'(HUE_TURN)) ? w_hue_sum - 10'(HUE_TURN) : w_hue_sum;
    assign w_hue_s2    = (w_hue_s1 >= 10'(HUE_TURN)) ? w_hue_s1 - 10'(HUE_TURN) : w_hue_s1;
    assign w_start_hue = (i_cfg_data >= 9'(HUE_TURN)) ? i_cfg_data - 9'(HUE_TURN)
                                                      : i_cfg_data;

    // ------------------------------------------------------------------
    // Shared divider step: one restoring quotient bit per cycle
    // ------------------------------------------------------------------
    logic [19:0] w_dsub;
    logic        w_dge;
    logic [19:0] w_rem_nx;
    logic [7:0]  w_quo_nx;

    assign w_dsub   = 20'(r_den) << r_step;
    assign w_dge    = (r_rem >= w_dsub);
    assign w_rem_nx = w_dge ? r_rem - w_dsub : r_rem;
    assign w_quo_nx = w_dge ? (r_quo | (8'd1 << r_step)) : r_quo;

    // color of the trail element being written
    logic [7:0]  w_r, w_g, w_b;

    always_comb begin
        w_r = 8'd0;
        w_g = 8'd0;
        w_b = 8'd0;
        if (r_cur_hue <= 9'd60) begin
            w_r = r_c;   w_g = r_quo;
        end else if (r_cur_hue <= 9'd120) begin
            w_r = r_quo; w_g = r_c;
        end else if (r_cur_hue <= 9'd180) begin
            w_g = r_c;   w_b = r_quo;
        end else if (r_cur_hue <= 9'd240) begin
            w_g = r_quo; w_b = r_c;
        end else if (r_cur_hue <= 9'd300) begin
            w_r = r_quo; w_b = r_c;
        end else begin
            w_r = r_c;   w_b = r_quo;
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rstate   <= R_NONE;
            r_phase    <= PH_RUN;
            r_ring_pos <= 6'd0;
            r_frames   <= 6'd0;
            r_cur_hue  <= 9'd0;
            r_off      <= 7'd0;
            r_mask     <= '0;
        end else begin
            r_state    <= n_state;
            r_rstate   <= n_rstate;
            r_phase    <= n_phase;
            r_ring_pos <= n_ring_pos;
            r_frames   <= n_frames;
            r_cur_hue  <= n_cur_hue;
            r_off      <= n_off;
            r_mask     <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_active <= n_active;
        r_pos    <= n_pos;
        r_fin    <= n_fin;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_den    <= n_den;
        r_step   <= n_step;
        r_c      <= n_c;
        r_i      <= n_i;
        r_idx    <= n_idx;
        r_drawn  <= n_drawn;
        r_k      <= n_k;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_rstate    = r_rstate;
        n_phase     = r_phase;
        n_ring_pos  = r_ring_pos;
        n_frames    = r_frames;
        n_cur_hue   = r_cur_hue;
        n_off       = r_off;
        n_active    = r_active;
        n_pos       = r_pos;
        n_fin       = r_fin;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_den       = r_den;
        n_step      = r_step;
        n_c         = r_c;
        n_i         = r_i;
        n_idx       = r_idx;
        n_drawn     = r_drawn;
        n_mask      = r_mask;
        n_k         = r_k;
        w_ram_we    = 1'b0;
        w_ram_wdata = {w_r, w_g, w_b};

        case (r_state)
            S_IDLE: begin
                // hold off while the previous frame is still streaming out
                if (i_valid && !o_stall) begin
                    // start a frame: reduce the ring position modulo the ring size
                    n_active = i_active;
                    n_mask   = '0;
                    n_rem    = 20'(r_ring_pos);
                    n_den    = 12'(w_p);
                    n_quo    = 8'd0;
                    n_step   = 3'd7;
                    n_state  = S_DIV_MOD;
                end
            end

            S_DIV_MOD: begin
                n_rem  = w_rem_nx;
                n_quo  = w_quo_nx;
                n_step = r_step - 3'd1;
                if (r_step == 3'd0) begin
                    n_state = S_SETUP;
                end
            end

            S_SETUP: begin
                n_pos   = r_rem[5:0];
                n_i     = 6'd0;
                n_idx   = r_rem[5:0];
                n_drawn = 6'd0;
                if (r_phase == PH_DONE) begin
                    // drained: black frame, skip painting
                    n_fin    = 1'b1;
                    n_k      = 6'd0;
                    n_rstate = R_READ;
                    n_state  = S_IDLE;
                end else begin
                    if (r_phase == PH_RUN && !r_active) begin
                        n_phase = PH_FINISH;
                        n_off   = {1'b0, r_rem[5:0]};
                    end
                    n_state = S_PAINT;
                end
            end

            S_PAINT: begin
                if (r_i >= r_trail_len || r_i > r_frames) begin
                    n_state = S_UPDATE;
                end else if (w_finishing && (8'(r_off) >= 8'(r_i) + 8'(w_p))) begin
                    // element already past the end of the sweep: drop it
                    n_i   = r_i + 6'd1;
                    n_idx = w_idx_dec;
                end else if (r_i == 6'd0) begin
                    // white head
                    w_ram_we      = 1'b1;
                    w_ram_wdata   = {CH_FULL, CH_FULL, CH_FULL};
                    n_mask[r_idx] = 1'b1;
                    n_drawn       = r_drawn + 6'd1;
                    n_i           = r_i + 6'd1;
                    n_idx         = w_idx_dec;
                end else begin
                    n_rem   = 20'(w_c_num);
                    n_den   = 12'(r_trail_len);
                    n_quo   = 8'd0;
                    n_step  = 3'd7;
                    n_state = S_DIV_C;
                end
            end

            S_DIV_C: begin
                n_rem  = w_rem_nx;
                n_quo  = w_quo_nx;
                n_step = r_step - 3'd1;
                if (r_step == 3'd0) begin
                    // hold the major channel, load the minor channel quotient
                    n_c     = w_quo_nx;
                    n_rem   = w_x_num;
                    n_den   = w_x_den;
                    n_quo   = 8'd0;
                    n_step  = 3'd7;
                    n_state = S_DIV_X;
                end
            end

            S_DIV_X: begin
                n_rem  = w_rem_nx;
                n_quo  = w_quo_nx;
                n_step = r_step - 3'd1;
                if (r_step == 3'd0) begin
                    n_state = S_WRITE;
                end
            end

            S_WRITE: begin
                w_ram_we      = 1'b1;
                n_mask[r_idx] = 1'b1;
                n_drawn       = r_drawn + 6'd1;
                n_i           = r_i + 6'd1;
                n_idx         = w_idx_dec;
                n_state       = S_PAINT;
            end

            S_UPDATE: begin
                n_fin = 1'b0;
                if (r_phase == PH_RUN) begin
                    n_ring_pos = w_next_pos;
                    n_frames   = (r_frames == FRAMES_MAX) ? r_frames : r_frames + 6'd1;
                    if (w_next_pos == 6'd0) begin
                        n_cur_hue = w_hue_s2[8:0];
                    end
                end else if ((8'(r_off) + 8'd1) >= (8'(w_p) + 8'(r_trail_len))) begin
                    n_phase = PH_DONE;
                    n_fin   = 1'b1;
                end else begin
                    n_off      = r_off + 7'd1;
                    n_ring_pos = w_next_pos;
                    n_frames   = (r_frames == FRAMES_MAX) ? r_frames : r_frames + 6'd1;
                end
                n_k      = 6'd0;
                n_rstate = R_READ;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // readout: issue the buffer read, then show the pixel until taken
        case (r_rstate)
            R_NONE: ;
            R_READ: begin
                n_rstate = R_SHOW;
            end
            R_SHOW: begin
                if (!i_stall) begin
                    if ((7'(r_k) + 7'd1) == w_p) begin
                        n_rstate = R_NONE;
                    end else begin
                        n_k      = r_k + 6'd1;
                        n_rstate = R_READ;
                    end
                end
            end
            default: begin
                n_rstate = R_NONE;
            end
        endcase

        // a start hue write loads the running hue at once
        if (i_cfg_we && i_cfg_index == CFG_START_HUE) begin
            n_cur_hue = w_start_hue;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_stall       = (r_state != S_IDLE) || (r_rstate != R_NONE);
    assign o_valid       = (r_rstate == R_SHOW);
    assign o_pixel_index = r_k;
    assign o_red         = r_mask[r_k] ? w_ram_q[23:16] : 8'd0;
    assign o_green       = r_mask[r_k] ? w_ram_q[15:8]  : 8'd0;
    assign o_blue        = r_mask[r_k] ? w_ram_q[7:0]   : 8'd0;
    assign o_frame_last  = ((7'(r_k) + 7'd1) == w_p);
    assign o_finished    = r_fin;

endmodule

// ----- bench/tb_comet_ring_frame_renderer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_comet_ring_frame_renderer_core : self-checking bench of the comet renderer
// Sends frame ticks and predicts every pixel beat of each frame in order. It
// checks the streamed pixels field by field while both channels idle and stall
// at random. It walks through register extremes, every hue sector, random
// sweeps, the finishing drain and the black frames after it.
// ============================================================================
module tb_comet_ring_frame_renderer_core;
    import crf_pkg::*;

    // Bound on the whole run
    localparam int CYCLE_LIMIT = 2_000_000;
    // Share of cycles, in percent, in which each side idles
    localparam int IDLE_PCT    = 29;

    // One pixel beat as the block should present it
    typedef struct {
        logic [5:0] index;
        logic [7:0] red, green, blue;
        logic       last;
        logic       fin;
    } t_pixel_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_active;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [5:0] o_pixel_index;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic       o_frame_last;
    logic       o_finished;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    comet_ring_frame_renderer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_active      (i_active),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_frame_last  (o_frame_last),
        .o_finished    (o_finished),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a shadow of the registers and of the effect, at the
    // block's widths, starting from the reset values.
    // ------------------------------------------------------------------------
    logic [6:0]  reg_pixels   = 7'd24;
    logic [5:0]  reg_trail    = 6'd12;
    logic [8:0]  reg_hue_step = '0;
    logic [5:0]  ring_pos     = '0;
    logic [5:0]  frames_drawn = '0;
    logic [8:0]  hue_now      = '0;
    t_phase      fx_phase     = PH_RUN;
    logic [6:0]  offset_end   = '0;
    logic [23:0] frame_px [MAX_PIXELS];

    // Pixel beats predicted but not yet seen, oldest first
    t_pixel_beat pixels_due[$];
    t_pixel_beat beat_want;

    bit idle_on = 1'b1;
    int err_count = 0;
    int ticks_sent = 0;
    int wind_down_ticks = 0;
    int pixels_checked = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Ring size in use: the register clamped to the supported range
    function automatic int ring_len();
        int p;
        p = int'(reg_pixels);
        if (p < MIN_PIXELS) p = MIN_PIXELS;
        if (p > MAX_PIXELS) p = MAX_PIXELS;
        return p;
    endfunction

    // Trail color at rank j of a trail of length len: full channel scaled by
    // (len-j)/len, the lesser channel by the hue's distance inside its sector
    function automatic logic [23:0] trail_color(int hue, int len, int rank);
        int q, f, c, x;
        logic [7:0] r, g, b;
        q = hue % 120;
        f = (q <= 60) ? q : 120 - q;
        c = (255 * (len - rank)) / len;
        x = (255 * (len - rank) * f) / (HUE_SECTOR * len);
        r = '0;
        g = '0;
        b = '0;
        if (hue <= 60) begin
            r = c[7:0];
            g = x[7:0];
        end else if (hue <= 120) begin
            r = x[7:0];
            g = c[7:0];
        end else if (hue <= 180) begin
            g = c[7:0];
            b = x[7:0];
        end else if (hue <= 240) begin
            g = x[7:0];
            b = c[7:0];
        end else if (hue <= 300) begin
            r = x[7:0];
            b = c[7:0];
        end else begin
            r = c[7:0];
            b = x[7:0];
        end
        return {r, g, b};
    endfunction

    // Draw head and trail into the frame; later elements win on a shared LED.
    // While finishing, elements past the end of the sweep are skipped and do
    // not take a rank, so the first one left shows at full value.
    function automatic void paint_comet(int p, bit finishing);
        int len, pos, rank, idx;
        len = int'(reg_trail);
        pos = int'(ring_pos) % p;
        rank = 0;
        foreach (frame_px[k]) frame_px[k] = '0;
        for (int i = 0; i < len; i++) begin
            if (i > int'(frames_drawn)) break;
            if (finishing && int'(offset_end) >= i + p) continue;
            idx = (pos + p - (i % p)) % p;
            frame_px[idx] = (i == 0) ? {3{CH_FULL}}
                                     : trail_color(int'(hue_now) % HUE_TURN, len, rank);
            rank++;
        end
    endfunction

    // Advance the head; turn the hue once per full sweep while running
    function automatic void step_ring(int p, bit turn_hue);
        ring_pos = 6'((int'(ring_pos) % p + 1) % p);
        if (frames_drawn != FRAMES_MAX) frames_drawn++;
        if (turn_hue && ring_pos == 0)
            hue_now = 9'((int'(hue_now) % HUE_TURN + int'(reg_hue_step)) % HUE_TURN);
    endfunction

    // Work out the frame that one accepted tick causes and queue its beats
    function automatic void render_frame(bit act);
        int p;
        bit done_flag;
        t_pixel_beat beat;
        p = ring_len();
        done_flag = 1'b0;
        if (fx_phase == PH_RUN && act) begin
            paint_comet(p, 1'b0);
            step_ring(p, 1'b1);
        end else if (fx_phase != PH_DONE) begin
            // First tick with active low starts the drain and draws already
            if (fx_phase == PH_RUN) begin
                fx_phase = PH_FINISH;
                offset_end = 7'(int'(ring_pos) % p);
            end
            paint_comet(p, 1'b1);
            if (int'(offset_end) + 1 >= p + int'(reg_trail)) begin
                fx_phase = PH_DONE;
                done_flag = 1'b1;
            end else begin
                offset_end++;
                step_ring(p, 1'b0);
            end
        end else begin
            foreach (frame_px[k]) frame_px[k] = '0;
            done_flag = 1'b1;
        end
        for (int k = 0; k < p; k++) begin
            beat.index = 6'(k);
            beat.red   = frame_px[k][23:16];
            beat.green = frame_px[k][15:8];
            beat.blue  = frame_px[k][7:0];
            beat.last  = (k == p - 1);
            beat.fin   = done_flag;
            pixels_due.push_back(beat);
        end
    endfunction

    function automatic void check_field(string name, int pix, int want, int got);
        if (want != got) begin
            $error("pixel %0d: %s expected %0d, got %0d", pix, name, want, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Pixel channel: check each accepted beat against the oldest prediction,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixels_due.size() == 0) begin
                $error("pixel beat %0d arrived with no frame pending", o_pixel_index);
                err_count++;
            end else begin
                beat_want = pixels_due.pop_front();
                check_field("pixel_index", beat_want.index, beat_want.index, o_pixel_index);
                check_field("red", beat_want.index, beat_want.red, o_red);
                check_field("green", beat_want.index, beat_want.green, o_green);
                check_field("blue", beat_want.index, beat_want.blue, o_blue);
                check_field("frame_last", beat_want.index, beat_want.last, o_frame_last);
                check_field("finished", beat_want.index, beat_want.fin, o_finished);
                pixels_checked++;
            end
        end
        i_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d pixel beats outstanding",
                     cycle_count, pixels_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one tick beat after a random gap, hold it until accepted, then
    // predict its frame. Valid stays high into the next tick when there is no gap.
    task automatic send_tick(input bit act);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_active <= act;
        do @(posedge i_clk); while (o_stall);
        render_frame(act);
        ticks_sent++;
        if (fx_phase != PH_RUN) wind_down_ticks++;
    endtask

    // Drop valid and hold off until every predicted pixel beat has come
    task automatic wait_frames_out();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pixels_due.size() != 0);
    endtask

    // Write one register while the block is idle and mirror it in the shadow
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PIXEL_COUNT:  reg_pixels = val[6:0];
            CFG_TRAIL_LENGTH: reg_trail = val[5:0];
            // A start hue write also reloads the running hue
            CFG_START_HUE:    hue_now = 9'(val % HUE_TURN);
            CFG_HUE_ADVANCE:  reg_hue_step = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Reset values: 24 LEDs, trail of 12, red; the trail grows frame by frame
    task automatic test_reset_defaults();
        repeat (3) send_tick(1'b1);
        wait_frames_out();
    endtask

    // Ring size and trail length at and beyond their limits
    task automatic test_ring_extremes();
        // Count 0 acts as 2; a trail far longer than the ring overwrites itself
        write_reg(CFG_PIXEL_COUNT, 9'd0);
        write_reg(CFG_TRAIL_LENGTH, 9'd63);
        repeat (2) send_tick(1'b1);
        wait_frames_out();
        // All ones: masked to 127, clamped to 64; zero trail gives a black frame
        write_reg(CFG_PIXEL_COUNT, 9'h1FF);
        write_reg(CFG_TRAIL_LENGTH, 9'd0);
        send_tick(1'b1);
        wait_frames_out();
        write_reg(CFG_TRAIL_LENGTH, 9'd32);
        send_tick(1'b1);
        wait_frames_out();
        // Shrink the ring under a head position beyond it; head only
        write_reg(CFG_PIXEL_COUNT, 9'd1);
        write_reg(CFG_TRAIL_LENGTH, 9'd1);
        send_tick(1'b1);
        wait_frames_out();
        write_reg(CFG_PIXEL_COUNT, 9'd65);
        write_reg(CFG_TRAIL_LENGTH, 9'd2);
        send_tick(1'b1);
        wait_frames_out();
    endtask

    // Every hue sector, its boundaries, a start hue past 359 and a wrapping step
    task automatic test_hue_sectors();
        logic [8:0] hues [11] = '{9'd0, 9'd60, 9'd61, 9'd120, 9'd150, 9'd180,
                                  9'd200, 9'd270, 9'd300, 9'd359, 9'd511};
        write_reg(CFG_PIXEL_COUNT, 9'd5);
        write_reg(CFG_TRAIL_LENGTH, 9'd5);
        write_reg(CFG_HUE_ADVANCE, 9'd0);
        foreach (hues[n]) begin
            write_reg(CFG_START_HUE, hues[n]);
            send_tick(1'b1);
            wait_frames_out();
        end
        // Step larger than a turn on a two-LED ring: the hue wraps every other frame
        write_reg(CFG_PIXEL_COUNT, 9'd2);
        write_reg(CFG_HUE_ADVANCE, 9'd500);
        repeat (3) send_tick(1'b1);
        wait_frames_out();
    endtask

    // Bursts of running frames under random settings, mostly small rings and
    // short trails, now and then any register value at all
    task automatic test_random_sweeps();
        int n, bursts, burst_len;
        logic [8:0] val;
        n = 0;
        bursts = 0;
        while (n < 250) begin
            wait_frames_out();
            // One long burst with no idling on either side
            idle_on = (bursts != 2);
            if (bursts == 0 || $urandom_range(3) != 0) begin
                val = 9'(($urandom_range(7) == 0) ? $urandom : $urandom_range(2, 24));
                write_reg(CFG_PIXEL_COUNT, val);
            end
            if (bursts == 0 || $urandom_range(2) != 0) begin
                val = 9'(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 12));
                write_reg(CFG_TRAIL_LENGTH, val);
            end
            if ($urandom_range(2) == 0) begin
                val = 9'($urandom);
                write_reg(CFG_START_HUE, val);
            end
            if ($urandom_range(2) == 0) begin
                val = ($urandom_range(1) == 0) ? 9'd10 : 9'($urandom);
                write_reg(CFG_HUE_ADVANCE, val);
            end
            burst_len = (bursts == 2) ? 40 : $urandom_range(5, 25);
            repeat (burst_len) begin
                send_tick(1'b1);
                n++;
            end
            bursts++;
        end
        wait_frames_out();
        idle_on = 1'b1;
    endtask

    // Drop active: run to the end of the sweep and drain the trail, with
    // active toggling freely and one trail length change along the way
    task automatic test_finish_drain();
        int n;
        logic [8:0] val;
        val = 9'($urandom_range(4, 12));
        write_reg(CFG_PIXEL_COUNT, val);
        val = 9'($urandom_range(2, 6));
        write_reg(CFG_TRAIL_LENGTH, val);
        send_tick(1'b0);
        n = 1;
        while (fx_phase != PH_DONE) begin
            if (n == 3) begin
                wait_frames_out();
                val = 9'($urandom_range(1, 8));
                write_reg(CFG_TRAIL_LENGTH, val);
            end
            send_tick(1'($urandom_range(1)));
            n++;
        end
        wait_frames_out();
    endtask

    // After the drain every tick gives a black frame marked finished
    task automatic test_finished_black();
        repeat (4) send_tick(1'($urandom_range(1)));
        wait_frames_out();
        write_reg(CFG_PIXEL_COUNT, 9'd64);
        repeat (3) send_tick(1'($urandom_range(1)));
        wait_frames_out();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_active    <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_PIXEL_COUNT;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_ring_extremes();
        test_hue_sectors();
        test_random_sweeps();
        test_finish_drain();
        test_finished_black();

        // Hold off for any stray beat after the last frame
        wait_frames_out();
        repeat (50) @(posedge i_clk);

        $display("Run covered %0d frame ticks (%0d finishing or finished) and %0d register writes,",
                 ticks_sent, wind_down_ticks, reg_writes);
        $display("with %0d pixel beats compared against predicted frames.", pixels_checked);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
